// ===== hw/rtl/pfom_pkg.sv =====
`default_nettype none

package pfom_pkg;

    // field widths
    localparam int unsigned OFFSET_W   = 32;
    localparam int unsigned MAPPED_W   = 33;
    localparam int unsigned PHASE_W    = 6;
    localparam int unsigned REM_W      = 5;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 5;
    localparam int unsigned PROD_W     = 64;

    // cadence kinds
    localparam logic [KIND_W-1:0] KIND_NTSC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ONE  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KIND  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAPE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE = 2'd2;

    // cadence geometry: each mask holds a single zero
    // ntsc 11011 has its zero at position 2, pal at position 12
    localparam logic [REM_W-1:0] NTSC_LEN  = 5'd5;
    localparam logic [REM_W-1:0] PAL_LEN   = 5'd25;
    localparam logic [REM_W-1:0] NTSC_ZERO = 5'd2;
    localparam logic [REM_W-1:0] PAL_ZERO  = 5'd12;

    // divider selects
    localparam logic [1:0] DIV_BY5  = 2'd0;
    localparam logic [1:0] DIV_BY25 = 2'd1;
    localparam logic [1:0] DIV_BY24 = 2'd2;
    localparam logic [1:0] DIV_BY4  = 2'd3;

    // reciprocals: ceil(2^s / d)
    localparam logic [31:0] RECIP_5  = 32'hCCCC_CCCD;  // s = 34
    localparam logic [31:0] RECIP_25 = 32'hA3D7_0A3E;  // s = 36
    localparam logic [31:0] RECIP_3  = 32'hAAAA_AAAB;  // s = 33, after a shift by 3
    localparam logic [31:0] RECIP_4  = 32'h4000_0000;  // s = 32

    typedef struct packed {
        logic                  neg;
        logic                  drop;
        logic                  ident;
        logic [1:0]            sel;
        logic [REM_W-1:0]      zero_gap;
        logic [OFFSET_W-1:0]   mag;
    } t_dec;

    typedef struct packed {
        logic                  neg;
        logic                  drop;
        logic                  ident;
        logic [1:0]            sel;
        logic [REM_W-1:0]      zero_gap;
        logic [OFFSET_W-1:0]   mag;
        logic [OFFSET_W-1:0]   quot;
    } t_quo;

    typedef struct packed {
        logic                  neg;
        logic                  drop;
        logic [REM_W-1:0]      zero_gap;
        logic [REM_W-1:0]      rem;
        logic [MAPPED_W-1:0]   scaled;
    } t_rem;

    // distance from the reduced phase to the zero of the mask, cyclically
    function automatic logic [REM_W-1:0] zero_dist(input logic [REM_W-1:0] phase,
                                                   input logic pal);
        logic [REM_W-1:0] len;
        logic [REM_W-1:0] zero;
        logic [REM_W-1:0] p;
        len  = pal ? PAL_LEN : NTSC_LEN;
        zero = pal ? PAL_ZERO : NTSC_ZERO;
        p    = phase;
        for (int i = 0; i < 6; i++) begin
            if (p >= len) begin
                p = p - len;
            end
        end
        if (p <= zero) begin
            zero_dist = zero - p;
        end else begin
            zero_dist = zero + len - p;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pfom_in_if.sv =====
`default_nettype none

interface pfom_in_if;
    import pfom_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [OFFSET_W-1:0]  frame_offset;
    logic                        reverse_dir;

    modport source (output valid, output frame_offset, output reverse_dir, input ready);
    modport sink   (input valid, input frame_offset, input reverse_dir, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pfom_out_if.sv =====
`default_nettype none

interface pfom_out_if;
    import pfom_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [MAPPED_W-1:0]  mapped_frames;
    logic signed [PHASE_W-1:0]   cadence_phase;

    modport source (output valid, output mapped_frames, output cadence_phase, input ready);
    modport sink   (input valid, input mapped_frames, input cadence_phase, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pulldown_frame_offset_mapper.sv =====
// Pulldown frame offset mapper: maps a signed frame offset through an ntsc two-three,
// pal (24 of 25) or one-to-one cadence, dropping or doubling frames as the tape_to_film
// register and the per-word reverse_dir bit select, and returns the mapped count with the
// input's sign plus the signed remainder within the cadence. It is a five stage pipeline
// (decode and magnitude, reciprocal multiply, remainder and cycle scaling, window count,
// sign and output register), so it takes one word per clock while the output side does
// not stall; the reciprocal multiplier stage sets the clock rate. Bubbles collapse, so
// a stall on the output side stops the pipe only once it is full. The user must write
// registers through the cfg port while no word is in flight; nothing here enforces it.
`default_nettype none

module pulldown_frame_offset_mapper (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    pfom_in_if.sink                                 i_in,
    pfom_out_if.source                              o_out,
    input  wire logic                               i_cfg_we,
    input  wire logic [pfom_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [pfom_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import pfom_pkg::*;

    // configuration
    logic [KIND_W-1:0] r_kind;
    logic              r_tape;
    logic [REM_W-1:0]  r_phase;

    // stage hand-off
    logic dec_valid;
    t_dec dec;
    logic div_ready;
    logic rem_valid;
    t_rem rem;
    logic cmb_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= KIND_NTSC;
            r_tape  <= 1'b0;
            r_phase <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KIND:  r_kind  <= i_cfg_data[KIND_W-1:0];
                REG_TAPE:  r_tape  <= i_cfg_data[0];
                REG_PHASE: r_phase <= i_cfg_data[REM_W-1:0];
                default:   ; // unused index, write ignored
            endcase
        end
    end

    // stage 1: sign split, direction and divisor choice, phase to zero distance
    pfom_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_kind  (r_kind),
        .i_tape  (r_tape),
        .i_phase (r_phase),
        .i_ready (div_ready),
        .o_valid (dec_valid),
        .o_dec   (dec)
    );

    // stages 2 and 3: quotient by reciprocal, remainder and full-cycle count
    pfom_divide u_divide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .i_dec   (dec),
        .o_ready (div_ready),
        .i_ready (cmb_ready),
        .o_valid (rem_valid),
        .o_rem   (rem)
    );

    // stages 4 and 5: partial window, sign, output register
    pfom_combine u_combine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rem_valid),
        .i_rem   (rem),
        .o_ready (cmb_ready),
        .o_out   (o_out)
    );
endmodule

`default_nettype wire

// ===== hw/rtl/pfom_decode.sv =====
`default_nettype none

module pfom_decode (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    pfom_in_if.sink                             i_in,
    input  wire logic [pfom_pkg::KIND_W-1:0]    i_kind,
    input  wire logic                           i_tape,
    input  wire logic [pfom_pkg::REM_W-1:0]     i_phase,
    input  wire logic                           i_ready,
    output logic                                o_valid,
    output pfom_pkg::t_dec                      o_dec
);
    import pfom_pkg::*;

    logic                r_valid;
    t_dec                r_dec;
    t_dec                n_dec;
    logic                advance;
    logic [OFFSET_W-1:0] raw;
    logic                pal;

    assign advance    = !r_valid || i_ready;
    assign i_in.ready = advance;

    always_comb begin
        raw         = i_in.frame_offset;
        pal         = (i_kind == KIND_PAL);
        n_dec.neg   = raw[OFFSET_W-1];
        n_dec.mag   = raw[OFFSET_W-1] ? (~raw + 32'd1) : raw;
        n_dec.drop  = i_tape ^ i_in.reverse_dir;
        n_dec.ident = (i_kind != KIND_NTSC) && (i_kind != KIND_PAL);
        if (n_dec.ident) begin
            n_dec.sel = DIV_BY4;
        end else if (n_dec.drop) begin
            n_dec.sel = pal ? DIV_BY25 : DIV_BY5;
        end else begin
            n_dec.sel = pal ? DIV_BY24 : DIV_BY4;
        end
        n_dec.zero_gap = zero_dist(i_phase, pal);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_in.valid) begin
            r_dec <= n_dec;
        end
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;
endmodule

`default_nettype wire

// ===== hw/rtl/pfom_divide.sv =====
`default_nettype none

module pfom_divide (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire pfom_pkg::t_dec   i_dec,
    output logic                  o_ready,
    input  wire logic             i_ready,
    output logic                  o_valid,
    output pfom_pkg::t_rem        o_rem
);
    import pfom_pkg::*;

    // quotient stage
    logic                r_qv;
    t_quo                r_quo;
    t_quo                n_quo;
    logic                adv_q;
    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [PROD_W-1:0]   prod;

    // remainder stage
    logic                r_rv;
    t_rem                r_rem;
    t_rem                n_rem;
    logic                adv_r;
    logic [MAPPED_W-1:0] q4;
    logic [MAPPED_W-1:0] q5;
    logic [MAPPED_W-1:0] q24;
    logic [MAPPED_W-1:0] q25;
    logic [MAPPED_W-1:0] back;

    assign adv_r   = !r_rv || i_ready;
    assign adv_q   = !r_qv || adv_r;
    assign o_ready = adv_q;

    // reciprocal multiply, quotient taken from the high bits
    always_comb begin
        mul_a = (i_dec.sel == DIV_BY24) ? {3'b000, i_dec.mag[OFFSET_W-1:3]} : i_dec.mag;
        case (i_dec.sel)
            DIV_BY5:  mul_b = RECIP_5;
            DIV_BY25: mul_b = RECIP_25;
            DIV_BY24: mul_b = RECIP_3;
            default:  mul_b = RECIP_4;
        endcase
        prod = {32'd0, mul_a} * {32'd0, mul_b};
        n_quo.neg      = i_dec.neg;
        n_quo.drop     = i_dec.drop;
        n_quo.ident    = i_dec.ident;
        n_quo.sel      = i_dec.sel;
        n_quo.zero_gap = i_dec.zero_gap;
        n_quo.mag      = i_dec.mag;
        case (i_dec.sel)
            DIV_BY5:  n_quo.quot = {2'b00, prod[63:34]};
            DIV_BY25: n_quo.quot = {4'b0000, prod[63:36]};
            DIV_BY24: n_quo.quot = {1'b0, prod[63:33]};
            default:  n_quo.quot = prod[63:32];
        endcase
    end

    // q times the divisor gives the remainder, q times the other figure the full cycles
    always_comb begin
        q4  = {1'b0, r_quo.quot} << 2;
        q5  = q4 + {1'b0, r_quo.quot};
        q24 = ({1'b0, r_quo.quot} << 4) + ({1'b0, r_quo.quot} << 3);
        q25 = q24 + {1'b0, r_quo.quot};
        case (r_quo.sel)
            DIV_BY5:  begin back = q5;  n_rem.scaled = q4;  end
            DIV_BY25: begin back = q25; n_rem.scaled = q24; end
            DIV_BY24: begin back = q24; n_rem.scaled = q25; end
            default:  begin back = q4;  n_rem.scaled = q5;  end
        endcase
        if (r_quo.ident) begin
            n_rem.scaled = {1'b0, r_quo.mag};
            n_rem.rem    = '0;
        end else begin
            n_rem.rem = r_quo.mag[REM_W-1:0] - back[REM_W-1:0];
        end
        n_rem.neg      = r_quo.neg;
        n_rem.drop     = r_quo.drop;
        n_rem.zero_gap = r_quo.zero_gap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv <= 1'b0;
            r_rv <= 1'b0;
        end else begin
            if (adv_q) begin
                r_qv <= i_valid;
            end
            if (adv_r) begin
                r_rv <= r_qv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_q && i_valid) begin
            r_quo <= n_quo;
        end
        if (adv_r && r_qv) begin
            r_rem <= n_rem;
        end
    end

    assign o_valid = r_rv;
    assign o_rem   = r_rem;
endmodule

`default_nettype wire

// ===== hw/rtl/pfom_combine.sv =====
`default_nettype none

module pfom_combine (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire pfom_pkg::t_rem   i_rem,
    output logic                  o_ready,
    pfom_out_if.source            o_out
);
    import pfom_pkg::*;

    logic                r_tv;
    logic                r_tneg;
    logic [REM_W-1:0]    r_trem;
    logic [MAPPED_W-1:0] r_total;
    logic [MAPPED_W-1:0] n_total;
    logic                adv_t;

    logic                r_ov;
    logic [MAPPED_W-1:0] r_mapped;
    logic [PHASE_W-1:0]  r_cphase;
    logic                adv_o;

    logic                extra;
    logic [REM_W-1:0]    win;

    assign adv_o   = !r_ov || o_out.ready;
    assign adv_t   = !r_tv || adv_o;
    assign o_ready = adv_t;

    // the window meets the single zero when it lies closer than the remainder
    always_comb begin
        extra   = (i_rem.zero_gap < i_rem.rem);
        win     = i_rem.drop ? (i_rem.rem - {{(REM_W-1){1'b0}}, extra})
                             : (i_rem.rem + {{(REM_W-1){1'b0}}, extra});
        n_total = i_rem.scaled + {{(MAPPED_W-REM_W){1'b0}}, win};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (adv_t) begin
                r_tv <= i_valid;
            end
            if (adv_o) begin
                r_ov <= r_tv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_t && i_valid) begin
            r_tneg  <= i_rem.neg;
            r_trem  <= i_rem.rem;
            r_total <= n_total;
        end
        if (adv_o && r_tv) begin
            r_mapped <= r_tneg ? (~r_total + 33'd1) : r_total;
            r_cphase <= r_tneg ? (~{1'b0, r_trem} + 6'd1) : {1'b0, r_trem};
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.mapped_frames = r_mapped;
    assign o_out.cadence_phase = r_cphase;
endmodule

`default_nettype wire

// ===== hw/rtl/pfom_checker.sv =====
`default_nettype none

module pfom_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    input  wire logic                            i_in_ready,
    input  wire logic                            i_out_valid,
    input  wire logic                            i_out_ready,
    input  wire logic [pfom_pkg::PHASE_W-1:0]    i_out_phase
);
    import pfom_pkg::*;

    logic [2:0] r_cnt;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_acc && !out_acc) begin
            r_cnt <= r_cnt + 3'd1;
        end else if (out_acc && !in_acc) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    // a word on the output was accepted before
    a_out_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_cnt != 3'd0))
        else $error("output word without an accepted input word");

    // five stages hold at most five words
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd5)
        else $error("more words in flight than pipeline stages");

    // an open output lets the whole pipe move
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled while output is ready");

    // the remainder stays within one cadence
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (($signed(i_out_phase) <= 6'sd24) && ($signed(i_out_phase) >= -6'sd24)))
        else $error("cadence phase out of range");

    // a stalled word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output word withdrawn under stall");
endmodule

bind pulldown_frame_offset_mapper pfom_checker u_pfom_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_phase (o_out.cadence_phase)
);

`default_nettype wire

// ===== dv/pulldown_frame_offset_mapper_tb.sv =====
`default_nettype none

module pulldown_frame_offset_mapper_tb;
    import pfom_pkg::*;

    // cadence patterns read from the msb, with their lengths and film frame counts
    localparam logic [31:0] NTSC_PATTERN = 32'hD800_0000;
    localparam logic [31:0] PAL_PATTERN  = 32'hFFF7_FF80;
    localparam logic [31:0] NTSC_SPAN    = 32'd5;
    localparam logic [31:0] PAL_SPAN     = 32'd25;
    localparam logic [31:0] NTSC_FILM    = 32'd4;
    localparam logic [31:0] PAL_FILM     = 32'd24;

    // kind code that the block has no cadence for, handled as one-to-one
    localparam logic [KIND_W-1:0] KIND_UNDEF = 2'd3;

    localparam int PHASES          = 31;
    localparam int WORDS_PER_PHASE = 50;
    localparam int PRESSURE_PHASE  = 5;
    localparam int HOLD_CYCLES     = 60;
    localparam int DRAIN_CYCLES    = 10;
    localparam int WATCHDOG_LIMIT  = 1000;

    typedef struct packed {
        logic signed [MAPPED_W-1:0] frames;
        logic signed [PHASE_W-1:0]  phase;
    } t_mapped_word;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic                tape;
        logic [4:0]          start;
        logic [OFFSET_W-1:0] offset;
        logic                rev;
        logic                typed;
        t_mapped_word        want;
    } t_directed_row;

    logic i_clk;
    logic i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    pfom_in_if  in_ch ();
    pfom_out_if out_ch ();

    pulldown_frame_offset_mapper dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // shadow copy of the registers, updated when written
    logic [KIND_W-1:0] cur_kind;
    logic              cur_tape;
    logic [4:0]        cur_start;

    t_mapped_word  pending_words [$];
    t_directed_row directed_rows [$];

    int errors;
    int words_sent;
    int words_checked;
    int settings_used;

    // per phase idle switches and the request for a long receiver hold
    bit send_idle;
    bit recv_idle;
    bit hold_req;

    initial begin
        i_clk = 1'b0;
        forever begin
            #10 i_clk = ~i_clk;
        end
    end

    // expected word for one offset under the current register copy
    function automatic t_mapped_word map_through_cadence(input logic [OFFSET_W-1:0] offset,
                                                         input logic rev);
        logic            neg;
        logic            drop;
        logic [31:0]     mag;
        logic [31:0]     pattern;
        logic [31:0]     span;
        logic [31:0]     film;
        logic [31:0]     pos;
        logic [31:0]     rem;
        logic [31:0]     need;
        longint unsigned quot;
        longint unsigned total;
        t_mapped_word    res;
        neg  = offset[31];
        mag  = neg ? (~offset + 32'd1) : offset;
        drop = cur_tape ^ rev;
        if (cur_kind == KIND_NTSC) begin
            pattern = NTSC_PATTERN;
            span    = NTSC_SPAN;
            film    = NTSC_FILM;
        end else if (cur_kind == KIND_PAL) begin
            pattern = PAL_PATTERN;
            span    = PAL_SPAN;
            film    = PAL_FILM;
        end else begin
            // identity: offset passes through sign-extended, no remainder
            res.frames = {offset[31], offset};
            res.phase  = '0;
            return res;
        end
        // a start position past the cadence wraps around it
        pos = {27'd0, cur_start} % span;
        if (drop) begin
            // full cycles keep their film frames, the tail counts ones in the window
            quot  = mag / span;
            rem   = mag % span;
            total = quot * film;
            for (int i = 0; i < rem; i++) begin
                total += pattern[31 - pos];
                pos = (pos + 1 == span) ? 32'd0 : pos + 1;
            end
        end else begin
            // full cycles expand to the span, the tail walks until its ones are met
            quot  = mag / film;
            rem   = mag % film;
            total = quot * span;
            need  = rem;
            for (int i = 0; i < 2 * PAL_SPAN && need != 0; i++) begin
                total += 1;
                if (pattern[31 - pos]) begin
                    need -= 1;
                end
                pos = (pos + 1 == span) ? 32'd0 : pos + 1;
            end
        end
        res.frames = neg ? (33'd0 - total[32:0]) : total[32:0];
        res.phase  = neg ? (6'd0 - rem[5:0]) : rem[5:0];
        return res;
    endfunction

    // mix of full range, small magnitudes, both extremes and whole cadence cycles
    function automatic logic [OFFSET_W-1:0] draw_offset();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6:    v = $urandom_range(0, 120) - 32'd60;
            7:          v = 32'h7FFF_FFFF - $urandom_range(0, 60);
            8:          v = 32'h8000_0000 + $urandom_range(0, 60);
            default: begin
                v = $urandom_range(0, 4000000) * 32'd600 + $urandom_range(0, 2) - 32'd1;
                if ($urandom_range(0, 1)) begin
                    v = ~v + 32'd1;
                end
            end
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        errors++;
        $display("mismatch on %s after %0d results: expected %0d, got %0d",
                 what, words_checked, want, got);
    endtask

    task automatic add_row(input logic [KIND_W-1:0] kind, input logic tape,
                           input logic [4:0] start, input logic [OFFSET_W-1:0] offset,
                           input logic rev, input logic typed,
                           input logic signed [MAPPED_W-1:0] frames,
                           input logic signed [PHASE_W-1:0] phase);
        t_directed_row row;
        row.kind        = kind;
        row.tape        = tape;
        row.start       = start;
        row.offset      = offset;
        row.rev         = rev;
        row.typed       = typed;
        row.want.frames = frames;
        row.want.phase  = phase;
        directed_rows.push_back(row);
    endtask

    // all three registers, one per cycle, write enable held across them
    task automatic set_config(input logic [KIND_W-1:0] kind, input logic tape,
                              input logic [4:0] start);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_KIND;
        cfg_data <= {3'd0, kind};
        @(posedge i_clk);
        cfg_idx  <= REG_TAPE;
        cfg_data <= {4'd0, tape};
        @(posedge i_clk);
        cfg_idx  <= REG_PHASE;
        cfg_data <= start;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        cur_kind  = kind;
        cur_tape  = tape;
        cur_start = start;
        settings_used++;
    endtask

    // lower valid, let every expected word arrive, then let the pipe empty
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // offer one word; valid stays high into the next call when no gap is drawn
    task automatic push_word(input logic [OFFSET_W-1:0] offset, input logic rev,
                             input t_mapped_word want);
        int gap;
        gap = send_idle ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.frame_offset <= offset;
        in_ch.reverse_dir  <= rev;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        pending_words.push_back(want);
        words_sent++;
    endtask

    // receiver: random stalls per word, plus one long hold on request
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        forever begin
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                stall = recv_idle ? $urandom_range(0, 4) : 0;
            end
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) begin
                @(posedge i_clk);
            end
        end
    end

    // result checker: each accepted word against the oldest expectation
    always @(posedge i_clk) begin
        t_mapped_word want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_words.size() == 0) begin
                report_mismatch("unexpected word", 0, longint'(out_ch.mapped_frames));
            end else begin
                want = pending_words.pop_front();
                if (want.frames !== out_ch.mapped_frames) begin
                    report_mismatch("mapped_frames", longint'(want.frames),
                                    longint'(out_ch.mapped_frames));
                end
                if (want.phase !== out_ch.cadence_phase) begin
                    report_mismatch("cadence_phase", longint'(want.phase),
                                    longint'(out_ch.cadence_phase));
                end
            end
            words_checked++;
        end
    end

    // watchdog: cycles in a row with no word moving on either side
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        t_directed_row row;
        t_mapped_word  want;
        logic [KIND_W-1:0]   kind;
        logic                tape;
        logic [4:0]          start;
        logic [OFFSET_W-1:0] offset;
        logic                rev;

        errors        = 0;
        words_sent    = 0;
        words_checked = 0;
        settings_used = 0;
        send_idle     = 1'b1;
        recv_idle     = 1'b1;
        hold_req      = 1'b0;
        cur_kind      = KIND_NTSC;
        cur_tape      = 1'b0;
        cur_start     = 5'd0;

        i_rst_n            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= REG_KIND;
        cfg_data           <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.frame_offset <= '0;
        in_ch.reverse_dir  <= 1'b0;

        // directed rows: kind, tape, start, offset, reverse, typed, frames, phase
        // reset settings: ntsc, doubling, start 0
        add_row(KIND_NTSC, 1'b0, 5'd0, 32'd0, 1'b0, 1'b1, 33'sd0, 6'sd0);
        add_row(KIND_NTSC, 1'b0, 5'd0, 32'h7FFF_FFFF, 1'b0, 1'b0, '0, '0);
        add_row(KIND_NTSC, 1'b0, 5'd0, 32'h8000_0000, 1'b0, 1'b1, -33'sd2684354560, 6'sd0);
        add_row(KIND_NTSC, 1'b0, 5'd0, 32'd7, 1'b1, 1'b0, '0, '0);
        add_row(KIND_NTSC, 1'b0, 5'd0, -32'sd7, 1'b0, 1'b0, '0, '0);
        // dropping, positive max is 429496729 cycles plus two ones
        add_row(KIND_NTSC, 1'b1, 5'd0, 32'h7FFF_FFFF, 1'b0, 1'b1, 33'sd1717986918, 6'sd2);
        add_row(KIND_NTSC, 1'b1, 5'd0, 32'h8000_0000, 1'b0, 1'b0, '0, '0);
        add_row(KIND_NTSC, 1'b1, 5'd0, -32'sd1, 1'b1, 1'b0, '0, '0);
        add_row(KIND_NTSC, 1'b1, 5'd3, 32'd4, 1'b0, 1'b0, '0, '0);
        add_row(KIND_NTSC, 1'b1, 5'd4, -32'sd9, 1'b0, 1'b0, '0, '0);
        // start positions past the ntsc cadence wrap
        add_row(KIND_NTSC, 1'b0, 5'd24, 32'd3, 1'b0, 1'b0, '0, '0);
        add_row(KIND_NTSC, 1'b1, 5'd31, 32'd4, 1'b0, 1'b0, '0, '0);
        // pal, window crossing the zero and the wrap
        add_row(KIND_PAL, 1'b0, 5'd0, 32'd23, 1'b0, 1'b0, '0, '0);
        add_row(KIND_PAL, 1'b0, 5'd12, -32'sd47, 1'b0, 1'b0, '0, '0);
        add_row(KIND_PAL, 1'b1, 5'd24, 32'd24, 1'b0, 1'b0, '0, '0);
        add_row(KIND_PAL, 1'b1, 5'd11, 32'h7FFF_FFFF, 1'b1, 1'b0, '0, '0);
        add_row(KIND_PAL, 1'b1, 5'd30, 32'h8000_0000, 1'b0, 1'b0, '0, '0);
        add_row(KIND_PAL, 1'b0, 5'd25, -32'sd1, 1'b0, 1'b0, '0, '0);
        // one-to-one and the undefined kind pass the offset through
        add_row(KIND_ONE, 1'b0, 5'd0, 32'h7FFF_FFFF, 1'b0, 1'b1, 33'sd2147483647, 6'sd0);
        add_row(KIND_ONE, 1'b1, 5'd0, 32'h8000_0000, 1'b1, 1'b1, -33'sd2147483648, 6'sd0);
        add_row(KIND_ONE, 1'b0, 5'd7, -32'sd5, 1'b0, 1'b1, -33'sd5, 6'sd0);
        add_row(KIND_UNDEF, 1'b1, 5'd0, 32'd12345, 1'b0, 1'b1, 33'sd12345, 6'sd0);
        add_row(KIND_UNDEF, 1'b0, 5'd17, 32'h8000_0000, 1'b1, 1'b1, -33'sd2147483648, 6'sd0);
        add_row(KIND_NTSC, 1'b0, 5'd0, 32'd1, 1'b0, 1'b0, '0, '0);

        // synchronous reset
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part: registers rewritten only when a row asks for new settings
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind != cur_kind || row.tape != cur_tape || row.start != cur_start) begin
                drain();
                set_config(row.kind, row.tape, row.start);
            end
            want = row.typed ? row.want : map_through_cadence(row.offset, row.rev);
            push_word(row.offset, row.rev, want);
        end

        // random part: one register setting per phase, extremes first
        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: begin kind = KIND_NTSC;  tape = 1'b0; start = 5'd0;  end
                1: begin kind = KIND_NTSC;  tape = 1'b1; start = 5'd4;  end
                2: begin kind = KIND_PAL;   tape = 1'b0; start = 5'd24; end
                3: begin kind = KIND_PAL;   tape = 1'b1; start = 5'd0;  end
                4: begin kind = KIND_PAL;   tape = 1'b1; start = 5'd31; end
                5: begin kind = KIND_NTSC;  tape = 1'b0; start = 5'd31; end
                6: begin kind = KIND_ONE;   tape = 1'b1; start = 5'd0;  end
                7: begin kind = KIND_UNDEF; tape = 1'b0; start = 5'd31; end
                default: begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: kind = KIND_NTSC;
                        4, 5, 6, 7: kind = KIND_PAL;
                        8:          kind = KIND_ONE;
                        default:    kind = KIND_UNDEF;
                    endcase
                    tape  = 1'($urandom_range(0, 1));
                    start = 5'($urandom_range(0, 31));
                end
            endcase
            set_config(kind, tape, start);

            // some phases run with no idling on one or both sides
            send_idle = (p % 4) != 1;
            recv_idle = (p % 3) != 2;
            if (p == PRESSURE_PHASE) begin
                // receiver holds off while the sender streams back to back
                send_idle = 1'b0;
                hold_req  = 1'b1;
            end

            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                offset = draw_offset();
                rev    = 1'($urandom_range(0, 1));
                push_word(offset, rev, map_through_cadence(offset, rev));
            end
        end

        drain();

        $display("sent %0d offsets under %0d register settings, checked %0d mapped words",
                 words_sent, settings_used, words_checked);
        $display("covered ntsc, pal, one-to-one and undefined kinds, both directions, wrapped starts");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/pfom_pkg.sv
hw/rtl/pfom_in_if.sv
hw/rtl/pfom_out_if.sv
hw/rtl/pfom_decode.sv
hw/rtl/pfom_divide.sv
hw/rtl/pfom_combine.sv
hw/rtl/pulldown_frame_offset_mapper.sv
hw/rtl/pfom_checker.sv
dv/pulldown_frame_offset_mapper_tb.sv
